@@ src/first_fit_line_allocator_assert.svh @@
// ----------------------------------------------------------------------------
// first_fit_line_allocator assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_LINE_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_LINE_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define FFLA_ASSERT(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("ffla assertion failed");
`define FFLA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ffla implication failed");
`else
`define FFLA_ASSERT(lbl, clk, rst, expr)
`define FFLA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`endif
`endif

@@ src/ffla_pkg.sv @@
// ----------------------------------------------------------------------------
// ffla_pkg
// Shared types, codes and reset values of the first fit line allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffla_pkg;

  localparam int ADDR_W    = 32;
  localparam int BASE_W    = 34;
  localparam int CFG_IDX_W = 8;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_HEAP_START = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT = 8'd1;

  localparam logic [ADDR_W-1:0] HEAP_START_RESET = 32'd0;
  localparam logic [ADDR_W-1:0] HEAP_LIMIT_RESET = 32'd65536;

  typedef struct packed {
    logic              granted;
    logic [ADDR_W-1:0] block_address;
  } result_t;

  typedef struct packed {
    logic write_line0;
    logic busy;
  } init_t;

endpackage

`default_nettype wire

@@ src/first_fit_line_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_line_allocator: first fit heap allocator with per-line headers
// Free: ST_FREE clears the busy flag, then ST_FINISH offers the result for output.
// Allocate: header reads (walks, merge), scans to heap end, a split, then ST_FINISH.
// Input waits until idle; reset or a write stalls it while line 0 is rebuilt.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_line_allocator #(
  parameter int MAX_LINES    = 1024,
  parameter int LINE_BYTES   = 64,
  parameter int HEADER_BYTES = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            operation,
  input  logic [ffla_pkg::ADDR_W-1:0]     request_bytes,
  input  logic [ffla_pkg::ADDR_W-1:0]     free_address,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            granted,
  output logic [ffla_pkg::ADDR_W-1:0]     block_address,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ffla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ffla_pkg::ADDR_W-1:0]     cfg_data
);
  import ffla_pkg::*;

  localparam int LINES_W = $clog2(MAX_LINES + 1);

  logic [LINES_W-1:0] heap_lines;
  logic [BASE_W-1:0]  base_hdr;
  init_t              init;
  logic               res_valid;
  logic               res_ready;
  result_t            result;

  ffla_geometry #(
    .MAX_LINES    (MAX_LINES),
    .LINE_BYTES   (LINE_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_geometry (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .heap_lines (heap_lines),
    .base_hdr   (base_hdr),
    .init       (init)
  );

  ffla_walker #(
    .MAX_LINES    (MAX_LINES),
    .LINE_BYTES   (LINE_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_walker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .request_bytes (request_bytes),
    .free_address  (free_address),
    .heap_lines    (heap_lines),
    .base_hdr      (base_hdr),
    .init          (init),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .result        (result)
  );

  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      granted       <= result.granted;
      block_address <= result.block_address;
    end
  end

endmodule

`default_nettype wire

@@ src/ffla_geometry.sv @@
// ----------------------------------------------------------------------------
// ffla_geometry
// Configuration registers and heap span: base line, line count, init request.
// ----------------------------------------------------------------------------
`default_nettype none

module ffla_geometry #(
  parameter int MAX_LINES    = 1024,
  parameter int LINE_BYTES   = 64,
  parameter int HEADER_BYTES = 4,
  localparam int LINES_W     = $clog2(MAX_LINES + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ffla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ffla_pkg::ADDR_W-1:0]     cfg_data,
  output logic [LINES_W-1:0]              heap_lines,
  output logic [ffla_pkg::BASE_W-1:0]     base_hdr,
  output ffla_pkg::init_t                 init
);
  import ffla_pkg::*;

  localparam int SH = $clog2(LINE_BYTES);

  logic [ADDR_W-1:0]  heap_start;
  logic [ADDR_W-1:0]  heap_limit;
  logic               pend;
  logic               wr;
  logic               cfg_take;
  logic [ADDR_W:0]    lo_line;
  logic [ADDR_W:0]    hi_line;
  logic [ADDR_W:0]    span;
  logic [ADDR_W:0]    lo_addr;
  logic [LINES_W-1:0] lines_calc;

  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid && cfg_ready;

  always_comb begin
    lo_line = ({1'b0, heap_start} + (ADDR_W + 1)'(LINE_BYTES - 1)) >> SH;
    hi_line = {1'b0, heap_limit} >> SH;
    span    = hi_line - lo_line;
    lo_addr = lo_line << SH;
    if (hi_line <= lo_line) begin
      lines_calc = '0;
    end else if (span > (ADDR_W + 1)'(MAX_LINES)) begin
      lines_calc = LINES_W'(MAX_LINES);
    end else begin
      lines_calc = span[LINES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_start <= HEAP_START_RESET;
      heap_limit <= HEAP_LIMIT_RESET;
      pend       <= 1'b1;
      wr         <= 1'b0;
    end else begin
      wr <= pend;
      if (cfg_take && cfg_index == REG_HEAP_START) begin
        heap_start <= cfg_data;
        pend       <= 1'b1;
      end else if (cfg_take && cfg_index == REG_HEAP_LIMIT) begin
        heap_limit <= cfg_data;
        pend       <= 1'b1;
      end else begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend) begin
      heap_lines <= lines_calc;
      base_hdr   <= {1'b0, lo_addr} + BASE_W'(HEADER_BYTES);
    end
  end

  assign init.write_line0 = wr;
  assign init.busy        = pend || wr;

endmodule

`default_nettype wire

@@ src/ffla_walker.sv @@
// ----------------------------------------------------------------------------
// ffla_walker
// Header memories and the sequencer that walks, splits, merges and frees.
// ----------------------------------------------------------------------------
`default_nettype none
`include "first_fit_line_allocator_assert.svh"

module ffla_walker #(
  parameter int MAX_LINES    = 1024,
  parameter int LINE_BYTES   = 64,
  parameter int HEADER_BYTES = 4,
  localparam int LINES_W     = $clog2(MAX_LINES + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         operation,
  input  logic [ffla_pkg::ADDR_W-1:0]  request_bytes,
  input  logic [ffla_pkg::ADDR_W-1:0]  free_address,
  input  logic [LINES_W-1:0]           heap_lines,
  input  logic [ffla_pkg::BASE_W-1:0]  base_hdr,
  input  ffla_pkg::init_t              init,
  output logic                         res_valid,
  input  logic                         res_ready,
  output ffla_pkg::result_t            result
);
  import ffla_pkg::*;

  localparam int IDX_W = $clog2(MAX_LINES);
  localparam int SH    = $clog2(LINE_BYTES);
  localparam logic [BASE_W-1:0] NEED_ADD = BASE_W'(HEADER_BYTES + LINE_BYTES - 1);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_FREE   = 4'd1;
  localparam logic [3:0] ST_RD     = 4'd2;
  localparam logic [3:0] ST_CHK    = 4'd3;
  localparam logic [3:0] ST_SPLIT  = 4'd4;
  localparam logic [3:0] ST_MRD    = 4'd5;
  localparam logic [3:0] ST_MCHK   = 4'd6;
  localparam logic [3:0] ST_MNRD   = 4'd7;
  localparam logic [3:0] ST_MNCHK  = 4'd8;
  localparam logic [3:0] ST_FINISH = 4'd9;

  logic               busy_mem [MAX_LINES];
  logic [LINES_W-1:0] lines_mem [MAX_LINES];

  logic [3:0]         state;
  logic [3:0]         state_next;
  logic [LINES_W-1:0] pos;
  logic [LINES_W-1:0] pos_next;
  logic [LINES_W-1:0] acc;
  logic [LINES_W-1:0] acc_next;
  logic               pass;
  logic               pass_next;
  logic [LINES_W-1:0] need;
  logic               too_big;
  logic [ADDR_W-1:0]  faddr;
  logic               res_granted;
  logic               res_granted_next;
  logic [ADDR_W-1:0]  res_addr;
  logic [ADDR_W-1:0]  res_addr_next;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               rd_busy;
  logic [LINES_W-1:0] rd_lines;
  logic               busy_we;
  logic [IDX_W-1:0]   busy_waddr;
  logic               busy_wdata;
  logic               lines_we;
  logic [IDX_W-1:0]   lines_waddr;
  logic [LINES_W-1:0] lines_wdata;

  logic               take;
  logic [BASE_W-1:0]  need_full;
  logic [BASE_W-1:0]  off_full;
  logic [BASE_W-1:0]  off_line;
  logic               free_ok;
  logic [BASE_W-1:0]  addr_full;
  logic [LINES_W-1:0] pos_len;
  logic [LINES_W-1:0] pos_acc;
  logic [LINES_W-1:0] pos_need;
  logic               fit;

  assign in_stall = (state != ST_IDLE) || init.busy;
  assign take     = in_valid && !in_stall;

  assign need_full = ({2'b0, request_bytes} + NEED_ADD) >> SH;
  assign off_full  = {2'b0, faddr} - base_hdr;
  assign off_line  = off_full >> SH;
  assign free_ok   = ({2'b0, faddr} >= base_hdr) && (off_full[SH-1:0] == '0) &&
                     (off_line < BASE_W'(heap_lines));
  assign addr_full = base_hdr + (BASE_W'(pos) << SH);
  assign pos_len   = pos + rd_lines;
  assign pos_acc   = pos + acc;
  assign pos_need  = pos + need;
  assign fit       = !rd_busy && !too_big && (rd_lines >= need);

  always_comb begin
    state_next       = state;
    pos_next         = pos;
    acc_next         = acc;
    pass_next        = pass;
    res_granted_next = res_granted;
    res_addr_next    = res_addr;
    rd_en            = 1'b0;
    rd_addr          = pos[IDX_W-1:0];
    busy_we          = 1'b0;
    busy_waddr       = pos[IDX_W-1:0];
    busy_wdata       = 1'b0;
    lines_we         = 1'b0;
    lines_waddr      = pos[IDX_W-1:0];
    lines_wdata      = acc;
    res_valid        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (init.write_line0) begin
          busy_we     = 1'b1;
          busy_waddr  = '0;
          busy_wdata  = 1'b0;
          lines_we    = 1'b1;
          lines_waddr = '0;
          lines_wdata = heap_lines;
        end
        if (take) begin
          pos_next   = '0;
          pass_next  = 1'b0;
          state_next = (operation == OP_FREE) ? ST_FREE : ST_RD;
        end
      end
      ST_FREE: begin
        busy_we          = free_ok;
        busy_waddr       = off_line[IDX_W-1:0];
        busy_wdata       = 1'b0;
        res_granted_next = 1'b1;
        res_addr_next    = '0;
        state_next       = ST_FINISH;
      end
      ST_RD: begin
        if (pos < heap_lines) begin
          rd_en      = 1'b1;
          state_next = ST_CHK;
        end else if (!pass) begin
          pos_next   = '0;
          state_next = ST_MRD;
        end else begin
          res_granted_next = 1'b0;
          res_addr_next    = '0;
          state_next       = ST_FINISH;
        end
      end
      ST_CHK: begin
        if (rd_lines == '0) begin
          pos_next = '0;
          if (!pass) begin
            state_next = ST_MRD;
          end else begin
            res_granted_next = 1'b0;
            res_addr_next    = '0;
            state_next       = ST_FINISH;
          end
        end else if (fit) begin
          busy_we          = 1'b1;
          busy_wdata       = 1'b1;
          res_granted_next = 1'b1;
          res_addr_next    = addr_full[ADDR_W-1:0];
          if (need < rd_lines) begin
            lines_we    = 1'b1;
            lines_wdata = need;
            acc_next    = rd_lines - need;
            state_next  = ST_SPLIT;
          end else begin
            state_next = ST_FINISH;
          end
        end else begin
          pos_next   = pos_len;
          state_next = ST_RD;
        end
      end
      ST_SPLIT: begin
        busy_we     = 1'b1;
        busy_waddr  = pos_need[IDX_W-1:0];
        busy_wdata  = 1'b0;
        lines_we    = 1'b1;
        lines_waddr = pos_need[IDX_W-1:0];
        lines_wdata = acc;
        state_next  = ST_FINISH;
      end
      ST_MRD: begin
        if (pos < heap_lines) begin
          rd_en      = 1'b1;
          state_next = ST_MCHK;
        end else begin
          pos_next   = '0;
          pass_next  = 1'b1;
          state_next = ST_RD;
        end
      end
      ST_MCHK: begin
        if (rd_lines == '0) begin
          pos_next   = '0;
          pass_next  = 1'b1;
          state_next = ST_RD;
        end else if (rd_busy) begin
          pos_next   = pos_len;
          state_next = ST_MRD;
        end else begin
          acc_next   = rd_lines;
          state_next = ST_MNRD;
        end
      end
      ST_MNRD: begin
        if (pos_acc < heap_lines) begin
          rd_en      = 1'b1;
          rd_addr    = pos_acc[IDX_W-1:0];
          state_next = ST_MNCHK;
        end else begin
          lines_we   = 1'b1;
          pos_next   = pos_acc;
          state_next = ST_MRD;
        end
      end
      ST_MNCHK: begin
        if (!rd_busy && rd_lines != '0) begin
          acc_next   = acc + rd_lines;
          state_next = ST_MNRD;
        end else begin
          lines_we   = 1'b1;
          pos_next   = pos_acc;
          state_next = ST_MRD;
        end
      end
      ST_FINISH: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    pos         <= pos_next;
    acc         <= acc_next;
    pass        <= pass_next;
    res_granted <= res_granted_next;
    res_addr    <= res_addr_next;
    if (take) begin
      faddr   <= free_address;
      need    <= need_full[LINES_W-1:0];
      too_big <= need_full > BASE_W'(MAX_LINES);
    end
  end

  always_ff @(posedge clk) begin
    if (busy_we) begin
      busy_mem[busy_waddr] <= busy_wdata;
    end
    if (lines_we) begin
      lines_mem[lines_waddr] <= lines_wdata;
    end
    if (rd_en) begin
      rd_busy  <= busy_mem[rd_addr];
      rd_lines <= lines_mem[rd_addr];
    end
  end

  assign result.granted       = res_granted;
  assign result.block_address = res_addr;

  `FFLA_ASSERT(a_no_rd_wr_overlap, clk, rst, !(rd_en && (busy_we || lines_we)))
  `FFLA_ASSERT_IMP(a_pos_in_heap, clk, rst, (state == ST_RD || state == ST_MRD),
                   pos <= heap_lines)
  `FFLA_ASSERT_IMP(a_split_in_heap, clk, rst, state == ST_SPLIT, pos_need < heap_lines)
  `FFLA_ASSERT_IMP(a_init_when_idle, clk, rst, init.write_line0, state == ST_IDLE)

endmodule

`default_nettype wire

@@ tb/heap_model_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_model_pkg
// Line-granular first fit heap predictor and result scoreboard used by the
// allocator testbench.
// ----------------------------------------------------------------------------
package heap_model_pkg;
  import ffla_pkg::*;

  localparam int              LINE_SLOTS = 1024;
  localparam longint unsigned LINE_SIZE  = 64;
  localparam longint unsigned HDR_SIZE   = 4;

  class heap_scoreboard;
    logic [ADDR_W-1:0] start_reg;
    logic [ADDR_W-1:0] limit_reg;
    bit                busy [LINE_SLOTS];
    int unsigned       span [LINE_SLOTS];
    longint unsigned   base;
    int unsigned       lines;
    result_t           expected_q [$];
    int                errors;
    int                results_seen;

    function new();
      start_reg    = HEAP_START_RESET;
      limit_reg    = HEAP_LIMIT_RESET;
      errors       = 0;
      results_seen = 0;
      rebuild();
    endfunction

    function void rebuild();
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned n;
      lo = start_reg;
      hi = limit_reg;
      lo = ((lo + LINE_SIZE - 1) / LINE_SIZE) * LINE_SIZE;
      hi = (hi / LINE_SIZE) * LINE_SIZE;
      n = 0;
      if (hi > lo) begin
        n = (hi - lo) / LINE_SIZE;
      end
      if (n > LINE_SLOTS) begin
        n = LINE_SLOTS;
      end
      base  = lo;
      lines = n;
      foreach (busy[i]) begin
        busy[i] = 1'b0;
        span[i] = 0;
      end
      span[0] = lines;
    endfunction

    function int first_fit(longint unsigned req);
      longint unsigned need_bytes;
      longint unsigned need;
      int unsigned     pos;
      int unsigned     len;
      int unsigned     nxt;
      need_bytes = req + HDR_SIZE;
      need       = (need_bytes + LINE_SIZE - 1) / LINE_SIZE;
      pos        = 0;
      while (pos < lines) begin
        len = span[pos];
        if (len == 0) begin
          return -1;
        end
        if (!busy[pos] && LINE_SIZE * len >= need_bytes) begin
          busy[pos] = 1'b1;
          if (need < len) begin
            nxt       = pos + need;
            span[pos] = need;
            busy[nxt] = 1'b0;
            span[nxt] = len - need;
          end
          return pos;
        end
        pos += len;
      end
      return -1;
    endfunction

    function void coalesce();
      int unsigned pos;
      int unsigned len;
      int unsigned nxt;
      pos = 0;
      while (pos < lines) begin
        len = span[pos];
        if (len == 0) begin
          return;
        end
        if (!busy[pos]) begin
          nxt = pos + len;
          while (nxt < lines && !busy[nxt] && span[nxt] != 0) begin
            len += span[nxt];
            nxt = pos + len;
          end
          span[pos] = len;
        end
        pos += len;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
      if (idx == REG_HEAP_START) begin
        start_reg = data;
      end else if (idx == REG_HEAP_LIMIT) begin
        limit_reg = data;
      end else begin
        return;
      end
      rebuild();
    endfunction

    function result_t note_item(logic op, logic [ADDR_W-1:0] req, logic [ADDR_W-1:0] fa);
      result_t         r;
      longint unsigned faddr;
      longint unsigned off;
      int              line;
      faddr           = fa;
      r.granted       = 1'b1;
      r.block_address = '0;
      if (op == OP_FREE) begin
        if (faddr >= base + HDR_SIZE) begin
          off = faddr - HDR_SIZE - base;
          if (off % LINE_SIZE == 0 && off / LINE_SIZE < lines) begin
            busy[off / LINE_SIZE] = 1'b0;
          end
        end
      end else begin
        line = first_fit(req);
        if (line < 0) begin
          coalesce();
          line = first_fit(req);
        end
        if (line < 0) begin
          r.granted = 1'b0;
        end else begin
          r.block_address = base + line * LINE_SIZE + HDR_SIZE;
        end
      end
      expected_q.push_back(r);
      return r;
    endfunction

    function void check_result(logic g, logic [ADDR_W-1:0] a);
      result_t e;
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer: granted %0d block_address 0x%08h", g, a);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (g !== e.granted) begin
        $error("granted: expected %0d actual %0d", e.granted, g);
        errors++;
      end
      if (a !== e.block_address) begin
        $error("block_address: expected 0x%08h actual 0x%08h", e.block_address, a);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: first fit line allocator
// Drives allocate and free requests with random gaps and output stalls over
// a range of heap spans, predicts each grant with a line-level heap model and
// compares every result transfer in order.
// ----------------------------------------------------------------------------
module testbench;
  import ffla_pkg::*;
  import heap_model_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int HOLD_CYCLES    = 400;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic                 operation;
  logic [ADDR_W-1:0]    request_bytes;
  logic [ADDR_W-1:0]    free_address;
  logic                 out_valid;
  logic                 out_stall;
  logic                 granted;
  logic [ADDR_W-1:0]    block_address;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_data;

  heap_scoreboard    sb;
  logic [ADDR_W-1:0] live_addrs [$];
  logic [ADDR_W-1:0] last_freed;
  int                items_sent;
  int                idle_cycles;

  first_fit_line_allocator dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .request_bytes (request_bytes),
    .free_address  (free_address),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .granted       (granted),
    .block_address (block_address),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(logic op, logic [ADDR_W-1:0] req, logic [ADDR_W-1:0] fa);
    result_t r;
    while (!(items_sent >= 900 && items_sent < 1200) && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    request_bytes <= req;
    free_address  <= fa;
    do @(posedge clk); while (in_stall);
    r = sb.note_item(op, req, fa);
    items_sent++;
    if (op == OP_ALLOC && r.granted) begin
      live_addrs.push_back(r.block_address);
    end
  endtask

  task automatic alloc(logic [ADDR_W-1:0] req);
    send_item(OP_ALLOC, req, $urandom());
  endtask

  task automatic give_back(logic [ADDR_W-1:0] fa);
    send_item(OP_FREE, $urandom(), fa);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // drain, then reprogram the span; the heap comes back as one free block
  task automatic set_heap(logic [ADDR_W-1:0] start_addr, logic [ADDR_W-1:0] limit_addr);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(REG_HEAP_START, start_addr);
    write_reg(REG_HEAP_LIMIT, limit_addr);
    cfg_valid <= 1'b0;
    live_addrs.delete();
  endtask

  task automatic random_items(int count);
    int                pick;
    int                k;
    int unsigned       span_bytes;
    logic [ADDR_W-1:0] req;
    logic [ADDR_W-1:0] fa;
    repeat (count) begin
      span_bytes = (sb.lines == 0) ? 256 : sb.lines * 64;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 55) begin
        if (pick < 50) begin
          req = $urandom_range(0, 127);
        end else if (pick < 75) begin
          req = $urandom_range(0, span_bytes);
        end else if (pick < 90) begin
          req = $urandom_range(1, 4) * 64 - 5 + $urandom_range(0, 2);
        end else begin
          req = $urandom();
        end
        alloc(req);
      end else begin
        if (live_addrs.size() != 0 && pick < 70) begin
          k  = $urandom_range(0, live_addrs.size() - 1);
          fa = live_addrs[k];
          live_addrs.delete(k);
          last_freed = fa;
        end else if (pick < 80) begin
          fa = last_freed;
        end else if (pick < 90 && live_addrs.size() != 0) begin
          fa = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
          case ($urandom_range(0, 2))
            0:       fa = fa + 32'd64;
            1:       fa = fa + 32'd1;
            default: fa = fa - 32'd4;
          endcase
        end else begin
          fa = $urandom();
        end
        give_back(fa);
      end
    end
  endtask

  initial begin
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        sb.check_result(granted, block_address);
      end
      if (!held && sb.results_seen >= 260) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= !(sb.results_seen >= 900 && sb.results_seen < 1200) &&
                   ($urandom_range(0, 99) < 21);
    end
  end

  initial begin
    sb            = new();
    items_sent    = 0;
    last_freed    = '0;
    idle_cycles   <= 0;
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    operation     <= OP_ALLOC;
    request_bytes <= '0;
    free_address  <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_HEAP_START;
    cfg_data      <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    alloc(32'd0);
    alloc(32'd60);
    alloc(32'd61);
    alloc(32'hFFFF_FFFF);
    give_back(32'd4);
    give_back(32'd68);
    alloc(32'd100);
    give_back(32'd196);
    give_back(32'd4);
    give_back(32'd5);
    give_back(32'd0);
    give_back(32'hFFFF_FFFF);
    give_back(32'd65540);
    give_back(32'd132);
    give_back(32'd260);
    alloc(32'd65532);
    alloc(32'd0);
    give_back(32'd4);
    alloc(32'd65533);
    alloc(32'd65532);
    give_back(32'd4);
    live_addrs.delete();

    random_items(150);
    set_heap(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_items(20);
    set_heap(32'h0000_0000, 32'h0000_0000);
    random_items(20);
    set_heap(32'h0000_1001, 32'h0000_127F);
    random_items(500);
    set_heap(32'hFFFF_0000, 32'hFFFF_FFFF);
    random_items(150);
    set_heap(32'h0001_2345, 32'h0001_2DA0);
    random_items(700);
    set_heap(32'h0000_0000, 32'hFFFF_FFFF);
    random_items(100);
    set_heap(32'h8000_0000, 32'h8000_00C0);
    random_items(300);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
